>>> rtl/core/srsd_pkg.sv
// ----------------------------------------------------------------------------
// srsd_pkg
// Shared types and constants of the sensor record stream decoder.
// ----------------------------------------------------------------------------
package srsd_pkg;

	localparam int MAX_RECORDS_DEF     = 16;
	localparam int VALUE_MAX_BYTES_DEF = 8;

	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 5;
	localparam int FMT_W     = 3;
	localparam int NUM_FMT   = 8;
	localparam int LEN_W     = 4;
	localparam int CNT_OUT_W = 5;
	localparam int VALUE_W   = 64;
	localparam int KIND_W    = 2;

	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 2;

	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 5;
	localparam int REG_ADDR_LSB = 2;

	typedef logic [NUM_FMT-1:0][LEN_W-1:0] len_table_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_RECORD = 2'd0,
		KIND_OK     = 2'd1,
		KIND_ERROR  = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_HEADER,
		PH_VALUE,
		PH_DRAIN
	} parse_phase_t;

	// Work for the back end caused by one input byte: an optional record
	// followed by an optional end status.
	typedef struct packed {
		logic                 rec_v;
		logic                 stat_v;
		logic                 stat_err;
		logic [BYTE_W-1:0]    sensor_type;
		logic [IDX_W-1:0]     sensor_index;
		logic [FMT_W-1:0]     format_code;
		logic [VALUE_W-1:0]   value_data;
		logic [LEN_W-1:0]     value_bytes;
		logic [CNT_OUT_W-1:0] record_count;
	} entry_t;

endpackage

>>> rtl/core/sensor_record_stream_decoder.sv
// Path: each byte's result beats are written into the work queue when the byte is
// accepted; from there they pass one by one into the output register to be taken.
// Throughput: one byte per cycle while in_stall is low; a byte that both closes a record
// and ends the payload gives two beats, which leave the single output register in turn.
// Reset: parser phase, counts, error flag, queue and output valid clear at once;
// the length registers reset to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
// sensor_record_stream_decoder
// Type-length-value record parser with a byte front end, a short work queue
// and a result back end.
// ----------------------------------------------------------------------------
module sensor_record_stream_decoder
	import srsd_pkg::*;
#(
	parameter int MAX_RECORDS     = MAX_RECORDS_DEF,
	parameter int VALUE_MAX_BYTES = VALUE_MAX_BYTES_DEF
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  end_of_buffer,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     result_kind,
	output logic [BYTE_W-1:0]     sensor_type,
	output logic [IDX_W-1:0]      sensor_index,
	output logic [FMT_W-1:0]      format_code,
	output logic [VALUE_W-1:0]    value_data,
	output logic [LEN_W-1:0]      value_bytes,
	output logic [CNT_OUT_W-1:0]  record_count,
	output logic                  last_of_run
);

	len_table_t len_table;
	entry_t     push_entry, head;
	logic       push, pop, q_full, not_empty;

	srsd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.len_table (len_table)
	);

	srsd_front #(
		.MAX_RECORDS     (MAX_RECORDS),
		.VALUE_MAX_BYTES (VALUE_MAX_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.len_table     (len_table),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	srsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty)
	);

	srsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.not_empty    (not_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.sensor_type  (sensor_type),
		.sensor_index (sensor_index),
		.format_code  (format_code),
		.value_data   (value_data),
		.value_bytes  (value_bytes),
		.record_count (record_count),
		.last_of_run  (last_of_run)
	);

endmodule

>>> rtl/core/srsd_regs.sv
// ----------------------------------------------------------------------------
// srsd_regs
// Register file of per-format value lengths behind an APB-style port.
// ----------------------------------------------------------------------------
module srsd_regs
	import srsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output len_table_t            len_table
);

	logic [NUM_FMT-1:0][LEN_W-1:0] len_q;
	logic [APB_ADDR_W-REG_ADDR_LSB-1:0] reg_idx;

	assign reg_idx = paddr[APB_ADDR_W-1:REG_ADDR_LSB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (psel && penable && pwrite) begin
			len_q[reg_idx] <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata    = {{(APB_DATA_W-LEN_W){1'b0}}, len_q[reg_idx]};
	assign pready    = 1'b1;
	assign len_table = len_q;

endmodule

>>> rtl/core/srsd_front.sv
// ----------------------------------------------------------------------------
// srsd_front
// Byte parser: tracks the record phase, collects value bytes and hands each
// byte's records and end status to the queue.
// ----------------------------------------------------------------------------
module srsd_front
	import srsd_pkg::*;
#(
	parameter int MAX_RECORDS     = MAX_RECORDS_DEF,
	parameter int VALUE_MAX_BYTES = VALUE_MAX_BYTES_DEF
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              end_of_buffer,
	input  len_table_t        len_table,
	input  logic              q_full,
	output logic              push,
	output entry_t            push_entry
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int ACC_W = VALUE_MAX_BYTES * BYTE_W;
	localparam int POS_W = (VALUE_MAX_BYTES > 1) ? $clog2(VALUE_MAX_BYTES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(VALUE_MAX_BYTES);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

	parse_phase_t phase_q, phase_d;
	logic [BYTE_W-1:0] type_q;
	logic [FMT_W-1:0]  fmt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ACC_W-1:0]  acc_q;
	logic [LEN_W-1:0]  left_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  vlen_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              err_q;

	logic fire;
	logic take_type, start_value, err_set, rec_hdr, rec_val, store_byte, rec_emit;
	logic [LEN_W-1:0] raw_len, hdr_len;
	logic [ACC_W-1:0] acc_new;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

	assign fire     = in_valid && !q_full;
	assign in_stall = q_full;

	assign raw_len = len_table[in_byte[BYTE_W-1:IDX_W]];
	assign hdr_len = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;

	// Decisions taken on the current byte.
	always_comb begin
		take_type   = 1'b0;
		start_value = 1'b0;
		err_set     = 1'b0;
		rec_hdr     = 1'b0;
		rec_val     = 1'b0;
		store_byte  = 1'b0;
		case (phase_q)
			PH_TYPE: begin
				if (!end_of_buffer) begin
					if (cnt_q >= MAX_CNT) begin
						err_set = 1'b1;
					end else begin
						take_type = 1'b1;
					end
				end
			end
			PH_HEADER: begin
				if (hdr_len == '0) begin
					rec_hdr = 1'b1;
				end else if (end_of_buffer) begin
					err_set = 1'b1;
				end else begin
					start_value = 1'b1;
				end
			end
			PH_VALUE: begin
				store_byte = 1'b1;
				if (left_q == LEN_W'(1)) begin
					rec_val = 1'b1;
				end else if (end_of_buffer) begin
					err_set = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rec_emit = rec_hdr || rec_val;

	// Next phase; the final byte of a payload always returns to the type byte.
	always_comb begin
		phase_d = phase_q;
		if (take_type) begin
			phase_d = PH_HEADER;
		end
		if (start_value) begin
			phase_d = PH_VALUE;
		end
		if (err_set) begin
			phase_d = PH_DRAIN;
		end
		if (rec_emit) begin
			phase_d = PH_TYPE;
		end
		if (end_of_buffer) begin
			phase_d = PH_TYPE;
		end
	end

	always_comb begin
		acc_new = acc_q;
		for (int i = 0; i < VALUE_MAX_BYTES; i++) begin
			if (pos_q == POS_W'(i)) begin
				acc_new[i*BYTE_W +: BYTE_W] = in_byte;
			end
		end
	end

	assign cnt_inc = cnt_q + CNT_W'(rec_emit);
	assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_inc};

	always_comb begin
		push_entry.rec_v        = rec_emit;
		push_entry.stat_v       = end_of_buffer;
		push_entry.stat_err     = err_q || err_set;
		push_entry.sensor_type  = type_q;
		push_entry.sensor_index = rec_hdr ? in_byte[IDX_W-1:0] : idx_q;
		push_entry.format_code  = rec_hdr ? in_byte[BYTE_W-1:IDX_W] : fmt_q;
		push_entry.value_data   = rec_hdr ? '0 : VALUE_W'(acc_new);
		push_entry.value_bytes  = rec_hdr ? '0 : vlen_q;
		push_entry.record_count = cnt_ext[CNT_OUT_W-1:0];
	end

	assign push = fire && (rec_emit || end_of_buffer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (end_of_buffer) begin
				cnt_q <= '0;
				err_q <= 1'b0;
			end else begin
				cnt_q <= cnt_inc;
				err_q <= err_q || err_set;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (take_type) begin
				type_q <= in_byte;
			end
			if (phase_q == PH_HEADER) begin
				fmt_q  <= in_byte[BYTE_W-1:IDX_W];
				idx_q  <= in_byte[IDX_W-1:0];
				vlen_q <= hdr_len;
				left_q <= hdr_len;
				pos_q  <= '0;
				acc_q  <= '0;
			end
			if (store_byte) begin
				acc_q  <= acc_new;
				left_q <= left_q - LEN_W'(1);
				pos_q  <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/srsd_queue.sv
// ----------------------------------------------------------------------------
// srsd_queue
// Short FIFO of parsed work between the front and the back end.
// ----------------------------------------------------------------------------
module srsd_queue
	import srsd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   not_empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> rtl/core/srsd_back.sv
// ----------------------------------------------------------------------------
// srsd_back
// Result sequencer: turns each queued entry into a record beat and/or an
// end status beat, held in an output register.
// ----------------------------------------------------------------------------
module srsd_back
	import srsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  entry_t               head,
	input  logic                 not_empty,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KIND_W-1:0]    result_kind,
	output logic [BYTE_W-1:0]    sensor_type,
	output logic [IDX_W-1:0]     sensor_index,
	output logic [FMT_W-1:0]     format_code,
	output logic [VALUE_W-1:0]   value_data,
	output logic [LEN_W-1:0]     value_bytes,
	output logic [CNT_OUT_W-1:0] record_count,
	output logic                 last_of_run
);

	logic                 out_valid_q;
	result_kind_t         kind_q;
	logic [BYTE_W-1:0]    type_q;
	logic [IDX_W-1:0]     idx_q;
	logic [FMT_W-1:0]     fmt_q;
	logic [VALUE_W-1:0]   value_q;
	logic [LEN_W-1:0]     vbytes_q;
	logic [CNT_OUT_W-1:0] count_q;
	logic                 last_q;
	logic                 rec_done_q;

	logic load, take, send_rec;

	assign load     = !out_valid_q || !out_stall;
	assign take     = load && not_empty;
	// The record part of the head entry goes out before its status.
	assign send_rec = head.rec_v && !rec_done_q;
	assign pop      = take && (!send_rec || !head.stat_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rec_done_q  <= 1'b0;
		end else if (load) begin
			out_valid_q <= not_empty;
			if (not_empty) begin
				rec_done_q <= send_rec && head.stat_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_q <= head.record_count;
			if (send_rec) begin
				kind_q   <= KIND_RECORD;
				type_q   <= head.sensor_type;
				idx_q    <= head.sensor_index;
				fmt_q    <= head.format_code;
				value_q  <= head.value_data;
				vbytes_q <= head.value_bytes;
				last_q   <= !head.stat_v;
			end else begin
				kind_q   <= head.stat_err ? KIND_ERROR : KIND_OK;
				type_q   <= '0;
				idx_q    <= '0;
				fmt_q    <= '0;
				value_q  <= '0;
				vbytes_q <= '0;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign sensor_type  = type_q;
	assign sensor_index = idx_q;
	assign format_code  = fmt_q;
	assign value_data   = value_q;
	assign value_bytes  = vbytes_q;
	assign record_count = count_q;
	assign last_of_run  = last_q;

endmodule

>>> tb/sensor_record_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// sensor_record_stream_decoder_tb
// Self-checking bench for the record stream decoder. Payload bytes go in over
// the valid/stall port and the length registers are set over APB. A scoreboard
// class predicts the record and status beats of every accepted byte, and each
// output beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module sensor_record_stream_decoder_tb;
	import srsd_pkg::*;

	typedef struct packed {
		result_kind_t         kind;
		logic [BYTE_W-1:0]    stype;
		logic [IDX_W-1:0]     sidx;
		logic [FMT_W-1:0]     fmt;
		logic [VALUE_W-1:0]   value;
		logic [LEN_W-1:0]     nbytes;
		logic [CNT_OUT_W-1:0] count;
		logic                 last;
	} decoded_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eob;
	} payload_byte_t;

	function automatic string describe(decoded_t r);
		return $sformatf("kind %0d type %h idx %0d fmt %0d value %h bytes %0d count %0d last %b",
			r.kind, r.stype, r.sidx, r.fmt, r.value, r.nbytes, r.count, r.last);
	endfunction

	class decode_scoreboard;
		logic [LEN_W-1:0]   len_tab [NUM_FMT];
		parse_phase_t       phase;
		logic [BYTE_W-1:0]  held_type;
		logic [FMT_W-1:0]   held_fmt;
		logic [IDX_W-1:0]   held_idx;
		logic [VALUE_W-1:0] acc;
		int                 left;
		int                 vlen;
		int                 rec_cnt;
		bit                 err_seen;
		decoded_t           expected_q [$];
		int                 mismatches;

		function new();
			foreach (len_tab[i]) len_tab[i] = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_TYPE;
			held_type = '0;
			held_fmt = '0;
			held_idx = '0;
			acc = '0;
			left = 0;
			vlen = 0;
			rec_cnt = 0;
			err_seen = 1'b0;
		endfunction

		function void set_length(int idx, logic [LEN_W-1:0] val);
			len_tab[idx] = val;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function decoded_t close_record();
			decoded_t r;
			rec_cnt++;
			phase = PH_TYPE;
			r.kind = KIND_RECORD;
			r.stype = held_type;
			r.sidx = held_idx;
			r.fmt = held_fmt;
			r.value = acc;
			r.nbytes = LEN_W'(vlen);
			r.count = CNT_OUT_W'(rec_cnt);
			r.last = 1'b0;
			return r;
		endfunction

		// Predicts the beats that one accepted payload byte causes.
		function void take_byte(logic [BYTE_W-1:0] b, logic eob);
			decoded_t outs [$];
			decoded_t st;
			int pos;
			case (phase)
				PH_TYPE: begin
					if (!eob) begin
						if (rec_cnt >= MAX_RECORDS_DEF) begin
							err_seen = 1'b1;
							phase = PH_DRAIN;
						end else begin
							held_type = b;
							phase = PH_HEADER;
						end
					end
				end
				PH_HEADER: begin
					held_fmt = b[7:5];
					held_idx = b[4:0];
					vlen = (len_tab[held_fmt] > VALUE_MAX_BYTES_DEF) ?
						VALUE_MAX_BYTES_DEF : int'(len_tab[held_fmt]);
					left = vlen;
					acc = '0;
					if (vlen == 0) outs.push_back(close_record());
					else if (eob) err_seen = 1'b1;
					else phase = PH_VALUE;
				end
				PH_VALUE: begin
					pos = (vlen - left) & 7;
					acc[8*pos +: 8] = b;
					left--;
					if (left == 0) outs.push_back(close_record());
					else if (eob) err_seen = 1'b1;
				end
				default: ;
			endcase
			if (eob) begin
				st = '0;
				st.kind = err_seen ? KIND_ERROR : KIND_OK;
				st.count = CNT_OUT_W'(rec_cnt);
				outs.push_back(st);
				restart();
			end
			if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
			foreach (outs[i]) expected_q.push_back(outs[i]);
		endfunction

		function void check_result(decoded_t got);
			decoded_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %s", describe(got));
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(got));
					end
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_stall;
	logic [BYTE_W-1:0]     in_byte;
	logic                  end_of_buffer;
	logic                  out_valid;
	logic                  out_stall;
	logic [KIND_W-1:0]     result_kind;
	logic [BYTE_W-1:0]     sensor_type;
	logic [IDX_W-1:0]      sensor_index;
	logic [FMT_W-1:0]      format_code;
	logic [VALUE_W-1:0]    value_data;
	logic [LEN_W-1:0]      value_bytes;
	logic [CNT_OUT_W-1:0]  record_count;
	logic                  last_of_run;

	decode_scoreboard sb;
	payload_byte_t    stim_q [$];
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               hold_req = 0;

	sensor_record_stream_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_buffer (end_of_buffer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.sensor_type   (sensor_type),
		.sensor_index  (sensor_index),
		.format_code   (format_code),
		.value_data    (value_data),
		.value_bytes   (value_bytes),
		.record_count  (record_count),
		.last_of_run   (last_of_run)
	);

	always #5 clk = ~clk;

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// Receiver side: random stalls, or a long hold-off when one is requested.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : monitor
		decoded_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = result_kind_t'(result_kind);
			got.stype = sensor_type;
			got.sidx = sensor_index;
			got.fmt = format_code;
			got.value = value_data;
			got.nbytes = value_bytes;
			got.count = record_count;
			got.last = last_of_run;
			sb.check_result(got);
		end
	end

	function automatic void push_byte(logic [BYTE_W-1:0] b, logic eob);
		payload_byte_t item;
		item.data = b;
		item.eob = eob;
		stim_q.push_back(item);
	endfunction

	function automatic int eff_len(logic [FMT_W-1:0] f);
		return (sb.len_tab[f] > VALUE_MAX_BYTES_DEF) ? VALUE_MAX_BYTES_DEF : int'(sb.len_tab[f]);
	endfunction

	// One payload: mostly well-formed records with random content, closed in
	// one of several ways; the rest is noise.
	function automatic void add_payload();
		int style;
		int nrec;
		int n;
		int cut;
		logic [FMT_W-1:0] f;
		style = $urandom_range(99);
		if (style < 15) begin
			n = $urandom_range(1, 12);
			repeat (n - 1) push_byte(BYTE_W'($urandom), 1'b0);
			push_byte(BYTE_W'($urandom), 1'b1);
			return;
		end
		nrec = ($urandom_range(9) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 5);
		repeat (nrec) begin
			f = FMT_W'($urandom);
			push_byte(BYTE_W'($urandom), 1'b0);
			push_byte({f, IDX_W'($urandom)}, 1'b0);
			repeat (eff_len(f)) push_byte(BYTE_W'($urandom), 1'b0);
		end
		style = $urandom_range(99);
		if (style < 55 && nrec > 0) begin
			stim_q[stim_q.size()-1].eob = 1'b1;
		end else if (style < 70) begin
			push_byte(BYTE_W'($urandom), 1'b1);
		end else if (style < 90) begin
			// The payload ends inside a record.
			f = FMT_W'($urandom);
			n = eff_len(f);
			push_byte(BYTE_W'($urandom), 1'b0);
			cut = (n <= 1) ? 0 : $urandom_range(0, n - 1);
			push_byte({f, IDX_W'($urandom)}, cut == 0);
			for (int i = 1; i <= cut; i++) push_byte(BYTE_W'($urandom), i == cut);
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 1; i <= n; i++) push_byte(BYTE_W'($urandom), i == n);
		end
	endfunction

	task automatic apb_write(int idx, logic [LEN_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(idx << REG_ADDR_LSB);
		pwdata <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_length(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_lengths(input int lens [NUM_FMT]);
		for (int i = 0; i < NUM_FMT; i++) apb_write(i, LEN_W'(lens[i]));
	endtask

	task automatic send_all();
		payload_byte_t item;
		while (stim_q.size() > 0) begin
			item = stim_q.pop_front();
			if ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
			end
			in_valid <= 1'b1;
			in_byte <= item.data;
			end_of_buffer <= item.eob;
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sb.take_byte(item.data, item.eob);
		end
		in_valid <= 1'b0;
	endtask

	// A byte in the middle of a record causes no beat, so the bench keeps clocking
	// after the last expected beat before the registers are touched.
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin : stimulus
		int lens [NUM_FMT];
		int k;
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		in_byte <= '0;
		end_of_buffer <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 70;
		lens = '{0, 1, 2, 8, 15, 3, 5, 7};
		program_lengths(lens);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'h5F, 1'b0);
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
		// Length 15 saturates to eight bytes; the last one also ends the payload.
		push_byte(8'hA5, 1'b0); push_byte(8'h95, 1'b0);
		for (int i = 0; i < 8; i++) push_byte(BYTE_W'(1 << i), i == 7);
		push_byte(8'h3C, 1'b1);
		push_byte(8'h11, 1'b0); push_byte(8'h61, 1'b0); push_byte(8'h22, 1'b1);
		push_byte(8'h12, 1'b0); push_byte(8'h21, 1'b1);
		push_byte(8'h7E, 1'b0); push_byte(8'h00, 1'b1);
		send_all();
		settle();

		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 11 : (p == 1) ? 70 : 0;
			recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 11 : 0;
			for (int s = 0; s < 2; s++) begin
				k = 2 * p + s;
				for (int i = 0; i < NUM_FMT; i++) begin
					case (k)
						0: lens[i] = 8;
						2: lens[i] = 15;
						4: lens[i] = 0;
						default: lens[i] = ($urandom_range(3) == 0) ?
							$urandom_range(9, 15) : $urandom_range(0, 8);
					endcase
				end
				program_lengths(lens);
				while (stim_q.size() < 165) add_payload();
				// Sometimes leave the payload open so the next register
				// setting lands in the middle of a record.
				if ($urandom_range(1) == 1)
					repeat ($urandom_range(1, 3)) if (stim_q.size() > 1) void'(stim_q.pop_back());
				if (p == 2 && s == 0) hold_req = 150;
				send_all();
				settle();
			end
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0 && !out_valid) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/srsd_pkg.sv
rtl/core/srsd_regs.sv
rtl/core/srsd_front.sv
rtl/core/srsd_queue.sv
rtl/core/srsd_back.sv
rtl/core/sensor_record_stream_decoder.sv
tb/sensor_record_stream_decoder_tb.sv
